/* design/triac_phase_angle_firing_assert.svh */
// Assertion macros shared by the triac firing block.
// All expect clk_i and rst_ni in scope.
`ifndef TRIAC_PHASE_ANGLE_FIRING_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_FIRING_ASSERT_SVH

// Same-cycle implication.
`define TPAF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpaf assertion failed");

// Next-cycle implication.
`define TPAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpaf assertion failed");

`endif

/* design/tpaf_pkg.sv */
package tpaf_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned PowerW = 10;
  localparam int unsigned PulseW = 7;
  localparam int unsigned IndexW = 2;
  localparam int unsigned DataW  = 16;

  localparam int unsigned FullScale     = 1000;
  localparam int unsigned DefPulseTicks = 100;
  localparam int unsigned RstLockout    = 5000;
  localparam int unsigned RstSpan       = 5000;

  // span * (1000 - power) fits in ProdW bits; /1000 = (>>3) then *ceil(2^30/125) >> 30
  localparam int unsigned ProdW      = CountW + PowerW;
  localparam int unsigned PreShift   = 3;
  localparam int unsigned RecipMul   = 8589935;
  localparam int unsigned RecipW     = 24;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned QuotFullW  = ProdW - PreShift + RecipW;
  localparam int unsigned CalcCycles = 2;
  localparam int unsigned CalcCntW   = 2;

  typedef enum logic [IndexW-1:0] {
    RegPower   = 2'd0,
    RegEnable  = 2'd1,
    RegLockout = 2'd2,
    RegSpan    = 2'd3
  } tpaf_reg_e;

  // Settings consumed by the event logic.
  typedef struct packed {
    logic              fire_enable;
    logic              power_nz;
    logic [CountW-1:0] lockout_ticks;
    logic [CountW-1:0] arm_delay;
  } tpaf_cfg_t;

  typedef struct packed {
    logic gate;
    logic armed;
    logic lockout_active;
  } tpaf_res_t;

endpackage

/* design/triac_phase_angle_firing.sv */
// Result path: each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one item per cycle while input is not held off; event state updates in a single pass.
// After reset, and after each config write, input is held off while
// the two-stage multiply pipeline (prod_q, quot_q) recomputes the firing delay.
// Reset (rst_ni, async low): counters cleared, disarmed, registers to defaults.
module triac_phase_angle_firing #(
  parameter int unsigned PULSE_TICKS = tpaf_pkg::DefPulseTicks
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tpaf_pkg::IndexW-1:0] cfg_index_i,
  input  logic [tpaf_pkg::DataW-1:0]  cfg_data_i,
  // event input: tick (kind 0) or zero-cross edge (kind 1) with mains level
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic                        level_i,
  // one result per input transfer
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        gate_o,
  output logic                        armed_o,
  output logic                        lockout_active_o
);

  tpaf_pkg::tpaf_cfg_t cfg;
  tpaf_pkg::tpaf_res_t res, res_out;
  logic                cfg_busy;
  logic                skid_full;
  logic                in_fire;

  // Config writes are always taken. The delay product is
  // span * (1000 - power) / 1000, formed in a registered pipeline apart from the
  // event path; input is held off while that pipeline refills.
  assign cfg_ready_o = 1'b1;

  tpaf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg),
    .busy_o  (cfg_busy)
  );

  // Input stalls only on a full skid stage, a pending delay recompute, or a
  // config write in the same cycle.
  assign in_ready_o = !skid_full && !cfg_busy && !cfg_valid_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Lockout, delay and pulse counters; result comes from the next state.
  tpaf_core #(
    .PULSE_TICKS (PULSE_TICKS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (in_fire),
    .kind_i  (kind_i),
    .level_i (level_i),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Output register plus skid entry takes one more transfer under stall; input is held off once the skid is full.
  tpaf_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .res_i       (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign gate_o           = res_out.gate;
  assign armed_o          = res_out.armed;
  assign lockout_active_o = res_out.lockout_active;

endmodule

/* design/tpaf_cfg_regs.sv */
`include "triac_phase_angle_firing_assert.svh"

module tpaf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_i,
  input  logic [tpaf_pkg::IndexW-1:0]  index_i,
  input  logic [tpaf_pkg::DataW-1:0]   data_i,
  output tpaf_pkg::tpaf_cfg_t          cfg_o,
  output logic                         busy_o
);

  logic [tpaf_pkg::PowerW-1:0]    power_q;
  logic                           enable_q;
  logic [tpaf_pkg::CountW-1:0]    lockout_q;
  logic [tpaf_pkg::CountW-1:0]    span_q;
  logic [tpaf_pkg::PowerW-1:0]    power_wr;
  logic [tpaf_pkg::ProdW-1:0]     prod_d, prod_q;
  logic [tpaf_pkg::QuotFullW-1:0] quot_full;
  logic [tpaf_pkg::CountW-1:0]    quot_q;
  logic [tpaf_pkg::CalcCntW-1:0]  calc_cnt_q;

  // saturate power writes at full scale (only data_i[PowerW-1:0] is compared)
  assign power_wr = (data_i[tpaf_pkg::PowerW-1:0] > tpaf_pkg::PowerW'(tpaf_pkg::FullScale)) ?
                    tpaf_pkg::PowerW'(tpaf_pkg::FullScale) : data_i[tpaf_pkg::PowerW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q   <= '0;
      enable_q  <= 1'b1;
      lockout_q <= tpaf_pkg::CountW'(tpaf_pkg::RstLockout);
      span_q    <= tpaf_pkg::CountW'(tpaf_pkg::RstSpan);
    end else if (wr_i) begin
      case (tpaf_pkg::tpaf_reg_e'(index_i))
        tpaf_pkg::RegPower:   power_q   <= power_wr;
        tpaf_pkg::RegEnable:  enable_q  <= data_i[0];
        tpaf_pkg::RegLockout: lockout_q <= data_i[tpaf_pkg::CountW-1:0];
        tpaf_pkg::RegSpan:    span_q    <= data_i[tpaf_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // delay = span * (1000 - power) / 1000, two registered multiplies
  assign prod_d = tpaf_pkg::ProdW'(span_q) *
                  tpaf_pkg::ProdW'(tpaf_pkg::PowerW'(tpaf_pkg::FullScale) - power_q);
  assign quot_full = tpaf_pkg::QuotFullW'(prod_q[tpaf_pkg::ProdW-1:tpaf_pkg::PreShift]) *
                     tpaf_pkg::QuotFullW'(tpaf_pkg::RecipMul);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quot_q <= quot_full[tpaf_pkg::RecipShift +: tpaf_pkg::CountW];
  end

  // counts down while the delay pipeline refills after reset or a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_cnt_q <= tpaf_pkg::CalcCntW'(tpaf_pkg::CalcCycles);
    end else if (wr_i) begin
      calc_cnt_q <= tpaf_pkg::CalcCntW'(tpaf_pkg::CalcCycles);
    end else if (calc_cnt_q != '0) begin
      calc_cnt_q <= calc_cnt_q - 1'b1;
    end
  end

  assign busy_o              = (calc_cnt_q != '0);
  assign cfg_o.fire_enable   = enable_q;
  assign cfg_o.power_nz      = (power_q != '0);
  assign cfg_o.lockout_ticks = lockout_q;
  assign cfg_o.arm_delay     = quot_q;

  `TPAF_ASSERT_NOW(a_power_sat, 1'b1, power_q <= tpaf_pkg::PowerW'(tpaf_pkg::FullScale))

endmodule

/* design/tpaf_core.sv */
`include "triac_phase_angle_firing_assert.svh"

module tpaf_core #(
  parameter int unsigned PULSE_TICKS = tpaf_pkg::DefPulseTicks
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic                kind_i,
  input  logic                level_i,
  input  tpaf_pkg::tpaf_cfg_t cfg_i,
  output tpaf_pkg::tpaf_res_t res_o
);

  logic [tpaf_pkg::CountW-1:0] lock_d, lock_q;
  logic [tpaf_pkg::CountW-1:0] delay_d, delay_q;
  logic [tpaf_pkg::PulseW-1:0] pulse_d, pulse_q;
  logic                        armed_d, armed_q;

  always_comb begin
    lock_d  = lock_q;
    delay_d = delay_q;
    pulse_d = pulse_q;
    armed_d = armed_q;
    if (!kind_i) begin
      // tick
      if (pulse_q != '0) pulse_d = pulse_q - 1'b1;
      if (lock_q != '0)  lock_d  = lock_q - 1'b1;
      if (armed_q) begin
        if (delay_q <= tpaf_pkg::CountW'(1)) begin
          armed_d = 1'b0;
          delay_d = '0;
          pulse_d = tpaf_pkg::PulseW'(PULSE_TICKS);
        end else begin
          delay_d = delay_q - 1'b1;
        end
      end
    end else if (lock_q == '0) begin
      // zero-cross edge outside lockout
      lock_d = cfg_i.lockout_ticks;
      if (level_i && cfg_i.fire_enable && cfg_i.power_nz && !armed_q) begin
        delay_d = cfg_i.arm_delay;
        armed_d = 1'b1;
      end else begin
        delay_d = '0;
        armed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q  <= '0;
      delay_q <= '0;
      pulse_q <= '0;
      armed_q <= 1'b0;
    end else if (acc_i) begin
      lock_q  <= lock_d;
      delay_q <= delay_d;
      pulse_q <= pulse_d;
      armed_q <= armed_d;
    end
  end

  assign res_o.gate           = (pulse_d != '0);
  assign res_o.armed          = armed_d;
  assign res_o.lockout_active = (lock_d != '0);

  `TPAF_ASSERT_NOW(a_idle_delay_clear, !armed_q, delay_q == '0)
  `TPAF_ASSERT_NEXT(a_lock_reload, acc_i && kind_i && (lock_q == '0),
                    lock_q == $past(cfg_i.lockout_ticks))
  `TPAF_ASSERT_NEXT(a_fire, acc_i && !kind_i && armed_q && (delay_q <= tpaf_pkg::CountW'(1)),
                    !armed_q && (pulse_q == tpaf_pkg::PulseW'(PULSE_TICKS)))

endmodule

/* design/tpaf_out_skid.sv */
`include "triac_phase_angle_firing_assert.svh"

module tpaf_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tpaf_pkg::tpaf_res_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpaf_pkg::tpaf_res_t res_o
);

  tpaf_pkg::tpaf_res_t main_q, skid_q;
  logic                main_valid_q, skid_valid_q;
  logic                out_fire;

  assign out_fire = main_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || out_fire) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid_q <= 1'b0;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) main_q <= skid_q;
    end else if (push_i) begin
      if (!main_valid_q || out_fire) main_q <= res_i;
      else                           skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign res_o       = main_q;

  `TPAF_ASSERT_NOW(a_skid_behind_main, skid_valid_q, main_valid_q)
  `TPAF_ASSERT_NEXT(a_skid_holds, skid_valid_q && !out_ready_i, skid_valid_q)

endmodule
